/* rtl/bbt_pkg.sv */
// Shared types, constants and byte-class functions of the brace block tokenizer.
// Used by every module under rtl; depends on nothing else.
package bbt_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int DEPTH_BITS  = 16;
   localparam int WORD_BITS   = 32;
   localparam int MAX_TOKENS  = 3;

   localparam logic [1:0] KIND_LIT   = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_IDENT = 2'd2;
   localparam logic [1:0] KIND_STMT  = 2'd3;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef struct packed {
      logic [1:0] kind;
      offset_type start_off;
      offset_type end_off;
      logic [7:0] first_byte;
   } token_type;

   typedef struct packed {
      logic [1:0]                 count;
      token_type [MAX_TOKENS-1:0] tok;
   } batch_type;

   function automatic logic is_white(logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic starts_ident(logic [7:0] b);
      return (b == CH_USCORE) || ((b >= 8'h61) && (b <= 8'h7A)) ||
             ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic in_ident(logic [7:0] b);
      return starts_ident(b) || ((b >= 8'h30) && (b <= 8'h39));
   endfunction

   function automatic logic [WORD_BITS-1:0] offset_to_word(offset_type v);
      logic [OFFSET_BITS+WORD_BITS-1:0] w;
      w = {{WORD_BITS{1'b0}}, v};
      return w[WORD_BITS-1:0];
   endfunction

endpackage

/* rtl/bbt_lexer.sv */
// Lexer state and the single-pass token logic for one source byte.
// Depends on bbt_pkg; produces a batch of up to three tokens per step.
module bbt_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               end_of_input,
   output bbt_pkg::batch_type batch
);

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_IDENT = 3'd1;
   localparam logic [2:0] MODE_MINUS = 3'd2;
   localparam logic [2:0] MODE_BLOCK = 3'd3;
   localparam logic [2:0] MODE_QUOTE = 3'd4;
   localparam logic [2:0] MODE_ESC   = 3'd5;

   localparam logic [bbt_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;

   logic [2:0]                    mode_ff, mode_in;
   bbt_pkg::offset_type           pos_ff, pos_in;
   bbt_pkg::offset_type           begin_ff, begin_in;
   logic [bbt_pkg::DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                          dquote_ff, dquote_in;
   logic [1:0]                    ilen_ff, ilen_in;
   logic                          fn_ff, fn_in;
   logic [7:0]                    first_ff, first_in;

   bbt_pkg::offset_type           pos_next;
   logic                          consumed;
   logic [1:0]                    cnt;
   logic [1:0]                    ident_kind;

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      depth_in   = depth_ff;
      dquote_in  = dquote_ff;
      ilen_in    = ilen_ff;
      fn_in      = fn_ff;
      first_in   = first_ff;
      pos_next   = pos_ff + 1'b1;
      consumed   = 1'b1;
      cnt        = 2'd0;
      batch      = '0;
      ident_kind = (ilen_ff == 2'd2 && fn_ff) ? bbt_pkg::KIND_LIT : bbt_pkg::KIND_IDENT;

      case (mode_ff)
         MODE_IDENT: begin
            if (bbt_pkg::in_ident(data_byte)) begin
               if (ilen_ff == 2'd1 && first_ff == bbt_pkg::CH_F && data_byte == bbt_pkg::CH_N)
                  fn_in = 1'b1;
               if (ilen_ff != 2'd3)
                  ilen_in = ilen_ff + 2'd1;
            end else begin
               batch.tok[cnt] = '{ident_kind, begin_ff, pos_ff, first_ff};
               cnt            = cnt + 2'd1;
               mode_in        = MODE_IDLE;
               consumed       = 1'b0;
            end
         end
         MODE_MINUS: begin
            mode_in = MODE_IDLE;
            if (data_byte == bbt_pkg::CH_GT) begin
               batch.tok[cnt] = '{bbt_pkg::KIND_LIT, begin_ff, pos_next, bbt_pkg::CH_MINUS};
            end else begin
               batch.tok[cnt] = '{bbt_pkg::KIND_LIT, begin_ff, pos_ff, bbt_pkg::CH_MINUS};
               consumed       = 1'b0;
            end
            cnt = cnt + 2'd1;
         end
         MODE_BLOCK: begin
            if (data_byte == bbt_pkg::CH_RBRACE) begin
               if (depth_ff <= 1) begin
                  depth_in       = '0;
                  batch.tok[cnt] = '{bbt_pkg::KIND_STMT, begin_ff, pos_next, bbt_pkg::CH_LBRACE};
                  cnt            = cnt + 2'd1;
                  mode_in        = MODE_IDLE;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
            end else if (data_byte == bbt_pkg::CH_LBRACE) begin
               if (depth_ff != DEPTH_MAX)
                  depth_in = depth_ff + 1'b1;
            end else if (data_byte == bbt_pkg::CH_DQUOTE || data_byte == bbt_pkg::CH_SQUOTE) begin
               dquote_in = (data_byte == bbt_pkg::CH_DQUOTE);
               mode_in   = MODE_QUOTE;
            end
         end
         MODE_QUOTE: begin
            if (data_byte == (dquote_ff ? bbt_pkg::CH_DQUOTE : bbt_pkg::CH_SQUOTE))
               mode_in = MODE_BLOCK;
            else if (data_byte == bbt_pkg::CH_BSLASH)
               mode_in = MODE_ESC;
         end
         MODE_ESC: begin
            mode_in = MODE_QUOTE;
         end
         default: begin
            mode_in  = MODE_IDLE;
            consumed = 1'b0;
         end
      endcase

      if (!consumed && !bbt_pkg::is_white(data_byte)) begin
         if (data_byte == bbt_pkg::CH_LBRACE) begin
            mode_in  = MODE_BLOCK;
            depth_in = {{(bbt_pkg::DEPTH_BITS-1){1'b0}}, 1'b1};
            begin_in = pos_ff;
            first_in = data_byte;
         end else if (data_byte == bbt_pkg::CH_MINUS) begin
            mode_in  = MODE_MINUS;
            begin_in = pos_ff;
            first_in = data_byte;
         end else if (bbt_pkg::starts_ident(data_byte)) begin
            mode_in  = MODE_IDENT;
            begin_in = pos_ff;
            first_in = data_byte;
            ilen_in  = 2'd1;
            fn_in    = 1'b0;
         end else begin
            batch.tok[cnt] = '{bbt_pkg::KIND_LIT, pos_ff, pos_next, data_byte};
            cnt            = cnt + 2'd1;
         end
      end

      if (end_of_input) begin
         if (mode_in == MODE_IDENT) begin
            batch.tok[cnt] = '{((ilen_in == 2'd2 && fn_in) ? bbt_pkg::KIND_LIT :
                                bbt_pkg::KIND_IDENT), begin_in, pos_next, first_in};
            cnt            = cnt + 2'd1;
         end else if (mode_in == MODE_MINUS) begin
            batch.tok[cnt] = '{bbt_pkg::KIND_LIT, begin_in, pos_next, bbt_pkg::CH_MINUS};
            cnt            = cnt + 2'd1;
         end
         batch.tok[cnt] = '{bbt_pkg::KIND_END, pos_next, pos_next, 8'h00};
         cnt            = cnt + 2'd1;
         mode_in   = MODE_IDLE;
         pos_in    = '0;
         begin_in  = '0;
         depth_in  = '0;
         dquote_in = 1'b0;
         ilen_in   = 2'd0;
         fn_in     = 1'b0;
         first_in  = 8'h00;
      end else begin
         pos_in = pos_next;
      end

      batch.count = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         begin_ff  <= '0;
         depth_ff  <= '0;
         dquote_ff <= 1'b0;
         ilen_ff   <= 2'd0;
         fn_ff     <= 1'b0;
         first_ff  <= 8'h00;
      end else if (step) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         depth_ff  <= depth_in;
         dquote_ff <= dquote_in;
         ilen_ff   <= ilen_in;
         fn_ff     <= fn_in;
         first_ff  <= first_in;
      end
   end

   a_depth_in_block: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_BLOCK || mode_ff == MODE_QUOTE || mode_ff == MODE_ESC) |->
      depth_ff != '0)
      else $error("Brace depth is zero inside a block.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && end_of_input |=> mode_ff == MODE_IDLE && pos_ff == '0)
      else $error("Lexer state not cleared after end of input.");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      step && end_of_input |-> batch.count != 2'd0 &&
      batch.tok[batch.count - 2'd1].kind == bbt_pkg::KIND_END)
      else $error("End of input did not close the batch with an end token.");

endmodule

/* rtl/bbt_rsp_queue.sv */
// Result register bank that holds one token batch and hands it out one token per transaction.
// Depends on bbt_pkg; drives the rsp_ stream of the top level.
module bbt_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bbt_pkg::batch_type batch,
   output logic               can_load,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,  // start offset, end offset, first byte
   output logic [1:0]         rsp_tuser,  // token_kind
   output logic               rsp_tlast   // last_of_run
);

   bbt_pkg::batch_type slots_ff, slots_in;
   logic [1:0]         idx_ff, idx_in;
   logic [1:0]         rem_ff, rem_in;
   bbt_pkg::token_type cur;

   assign rsp_tvalid = (rem_ff != 2'd0);
   assign can_load   = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_tready);
   assign cur        = slots_ff.tok[idx_ff];
   assign rsp_tdata  = {cur.first_byte, bbt_pkg::offset_to_word(cur.end_off),
                        bbt_pkg::offset_to_word(cur.start_off)};
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = (rem_ff == 2'd1);

   always_comb begin
      slots_in = slots_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      if (load) begin
         slots_in = batch;
         idx_in   = 2'd0;
         rem_in   = batch.count;
      end else if (rsp_tvalid && rsp_tready) begin
         idx_in = idx_ff + 2'd1;
         rem_in = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         idx_ff <= 2'd0;
         rem_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         rem_ff <= rem_in;
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, idx_ff} + {1'b0, rem_ff}) <= 3'd3)
      else $error("Result slot index runs past the batch.");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load && batch.count != 2'd0 |=> rsp_tvalid && idx_ff == 2'd0)
      else $error("Loaded batch is not presented.");

endmodule

/* rtl/brace_block_tokenizer.sv */
// Brace block tokenizer: the input register, the lexer and the result queue.
// Depends on bbt_pkg, bbt_lexer and bbt_rsp_queue.
// The block takes one source byte per transaction and returns its tokens one per
// transaction; a registered byte is lexed once the result queue can take its batch,
// so a stream whose bytes each cause at most one token flows at one byte per clock
// while rsp_tready is high. A byte that completes two or three tokens (e.g. an
// identifier ended by a literal, with end of input) holds the input until the
// single result port is on its last token. The final byte of a text is marked by
// req_tlast and always yields an END token; the next starts a new text at offset 0.
module brace_block_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // start offset, end offset, first byte
   output logic [1:0]  rsp_tuser,   // token_kind
   output logic        rsp_tlast    // last_of_run
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               can_load;
   logic               step;
   bbt_pkg::batch_type batch;

   assign step        = in_valid_ff && can_load;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = req_tvalid || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   bbt_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .end_of_input (in_last_ff),
      .batch        (batch)
   );

   bbt_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .batch      (batch),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("Pending input byte lost while stalled.");

endmodule
